[src/mtee_pkg.sv]
package mtee_pkg;

    localparam int TRACKS_DEF = 128;

    localparam int TRACK_W = 7;
    localparam int TICK_W  = 28;
    localparam int D2_W    = 15;
    localparam int VLQ_N   = 4;
    localparam int MSG_N   = 10;
    localparam int IDX_W   = 4;
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 5;
    localparam int M_DATA_W = 16;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_EVENT = 2'd1;
    localparam logic [1:0] OP_EOT   = 2'd2;

    localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
    localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
    localparam logic [2:0] KIND_PROGRAM  = 3'd2;
    localparam logic [2:0] KIND_CONTROL  = 3'd3;
    localparam logic [2:0] KIND_PITCH    = 3'd4;

    localparam logic [7:0] ST_NOTE    = 8'h90;
    localparam logic [7:0] ST_CONTROL = 8'hB0;
    localparam logic [7:0] ST_PROGRAM = 8'hC0;
    localparam logic [7:0] ST_PITCH   = 8'hE0;
    localparam logic [7:0] CC_BANK_MSB = 8'h00;
    localparam logic [7:0] CC_BANK_LSB = 8'h20;
    localparam logic [7:0] META_MARK  = 8'hFF;
    localparam logic [7:0] META_EOT   = 8'h2F;

endpackage

[src/midi_track_event_encoder_top.sv]
// Encodes ticks and MIDI events into Standard MIDI File track bytes, one byte per
// output transfer, tagged with its track and with tlast on the final byte of each
// input transfer. An event yields 3 to 14 bytes (a variable-length delta of 1 to 4
// bytes, then the message), an end of track yields 4 bytes, and a tick or an ignored
// item yields none. The output gives one byte per cycle unless m_tready holds it back.
// An item passes from a registered input stage to the byte serializer and then to a
// registered output stage, and a new item can be taken while the serializer is still
// busy with the last one. After reset the per-track tick memory is cleared, during
// which s_tready stays low.
module midi_track_event_encoder_top
    import mtee_pkg::*;
#(
    parameter int TRACKS = TRACKS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // track[6:0], data_one[14:7], data_two[29:15], command_byte[36:30], zero fill.
    input  logic [S_DATA_W-1:0] s_tdata,
    // op[1:0], kind[4:2].
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_byte[7:0], out_track[14:8], zero fill.
    output logic [M_DATA_W-1:0] m_tdata,
    // last_byte.
    output logic                m_tlast
);

    localparam int DEPTH = (TRACKS < 128) ? TRACKS : 128;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [TRACK_W-1:0] in_trk;
    logic [7:0]         in_d1;
    logic [D2_W-1:0]    in_d2;
    logic [6:0]         in_cmd;
    logic [1:0]         in_op;
    logic [2:0]         in_kind;
    logic               in_range;
    logic               s_xfer;
    logic               is_event;
    logic               is_eot;

    logic [TICK_W-1:0]  tick_now_reg;
    logic [TICK_W-1:0]  mem [DEPTH];
    logic               clr_active_reg;
    logic [AW-1:0]      clr_cnt_reg;

    logic               a_valid_reg;
    logic               a_eot_reg;
    logic [2:0]         a_kind_reg;
    logic [7:0]         a_d1_reg;
    logic [D2_W-1:0]    a_d2_reg;
    logic [6:0]         a_cmd_reg;
    logic [TRACK_W-1:0] a_trk_reg;
    logic [TICK_W-1:0]  a_tick_reg;
    logic [TICK_W-1:0]  a_rd_reg;

    logic               b_valid_reg;
    logic [7:0]         b_vlq_reg [VLQ_N];
    logic [7:0]         b_msg_reg [MSG_N];
    logic [1:0]         b_ng_reg;
    logic [IDX_W-1:0]   b_last_reg;
    logic [IDX_W-1:0]   b_idx_reg;
    logic [TRACK_W-1:0] b_trk_reg;

    logic [7:0]         b_vlq_next [VLQ_N];
    logic [7:0]         b_msg_next [MSG_N];
    logic [1:0]         b_ng_next;
    logic [IDX_W-1:0]   b_last_next;
    logic [TICK_W-1:0]  delta;
    logic [6:0]         grp [VLQ_N];
    logic [IDX_W-1:0]   nm;
    logic [7:0]         st_ctl;
    logic [13:0]        bend;

    logic               c_valid_reg;
    logic [7:0]         c_byte_reg;
    logic [TRACK_W-1:0] c_trk_reg;
    logic               c_last_reg;

    logic               c_free;
    logic               b_emit;
    logic               b_done;
    logic               b_free;
    logic               a_adv;
    logic [7:0]         b_byte;
    logic [IDX_W-1:0]   msg_idx;

    assign in_trk  = s_tdata[6:0];
    assign in_d1   = s_tdata[14:7];
    assign in_d2   = s_tdata[29:15];
    assign in_cmd  = s_tdata[36:30];
    assign in_op   = s_tuser[1:0];
    assign in_kind = s_tuser[4:2];

    assign in_range = (32'(in_trk) < 32'(TRACKS));
    assign is_event = (in_op == OP_EVENT) && in_range && (in_kind <= KIND_PITCH);
    assign is_eot   = (in_op == OP_EOT) && in_range;

    assign c_free   = !c_valid_reg || m_tready;
    assign b_emit   = b_valid_reg && c_free;
    assign b_done   = b_emit && (b_idx_reg == b_last_reg);
    assign b_free   = !b_valid_reg || b_done;
    assign a_adv    = a_valid_reg && b_free;
    assign s_tready = !clr_active_reg && (!a_valid_reg || a_adv);
    assign s_xfer   = s_tvalid && s_tready;

    // Per-track tick of the last event, read and written at the input transfer.
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (s_xfer && is_event)
        begin
            mem[in_trk[AW-1:0]] <= tick_now_reg;
        end
        if (s_xfer)
        begin
            a_rd_reg <= mem[in_trk[AW-1:0]];
        end
    end

    always_comb
    begin
        delta = a_tick_reg - a_rd_reg;
        for (int g = 0; g < VLQ_N; g++)
        begin
            grp[g] = delta[7*g +: 7];
        end
        if (a_eot_reg)
        begin
            b_ng_next = 2'd0;
        end
        else if (grp[3] != 7'd0)
        begin
            b_ng_next = 2'd3;
        end
        else if (grp[2] != 7'd0)
        begin
            b_ng_next = 2'd2;
        end
        else if (grp[1] != 7'd0)
        begin
            b_ng_next = 2'd1;
        end
        else
        begin
            b_ng_next = 2'd0;
        end
        for (int i = 0; i < VLQ_N; i++)
        begin
            if (a_eot_reg || (2'(i) > b_ng_next))
            begin
                b_vlq_next[i] = 8'h00;
            end
            else
            begin
                b_vlq_next[i] = {(2'(i) < b_ng_next), grp[2'(b_ng_next - 2'(i))]};
            end
        end

        st_ctl = ST_CONTROL + a_d2_reg[7:0];
        bend   = {a_d1_reg[5:0], 8'h00} + a_d2_reg[13:0];
        for (int i = 0; i < MSG_N; i++)
        begin
            b_msg_next[i] = 8'h00;
        end
        nm = 4'd3;
        if (a_eot_reg)
        begin
            b_msg_next[0] = META_MARK;
            b_msg_next[1] = META_EOT;
            b_msg_next[2] = 8'h00;
        end
        else
        begin
            case (a_kind_reg)
                KIND_NOTE_OFF, KIND_NOTE_ON:
                begin
                    b_msg_next[0] = ST_NOTE + {4'h0, a_d1_reg[3:0]};
                    b_msg_next[1] = {1'b0, a_cmd_reg};
                    b_msg_next[2] = (a_kind_reg == KIND_NOTE_OFF) ? 8'h00 : a_d2_reg[7:0];
                end
                KIND_PROGRAM:
                begin
                    if (!a_d2_reg[D2_W-1])
                    begin
                        nm = 4'd10;
                        b_msg_next[0] = st_ctl;
                        b_msg_next[1] = CC_BANK_MSB;
                        b_msg_next[2] = {1'b0, a_d2_reg[13:7]};
                        b_msg_next[3] = 8'h00;
                        b_msg_next[4] = st_ctl;
                        b_msg_next[5] = CC_BANK_LSB;
                        b_msg_next[6] = {1'b0, a_d2_reg[6:0]};
                        b_msg_next[7] = 8'h00;
                        b_msg_next[8] = ST_PROGRAM + a_d2_reg[7:0];
                        b_msg_next[9] = {1'b0, a_cmd_reg};
                    end
                    else
                    begin
                        nm = 4'd2;
                        b_msg_next[0] = ST_PROGRAM + a_d2_reg[7:0];
                        b_msg_next[1] = {1'b0, a_cmd_reg};
                    end
                end
                KIND_CONTROL:
                begin
                    b_msg_next[0] = st_ctl;
                    b_msg_next[1] = {1'b0, a_cmd_reg};
                    b_msg_next[2] = a_d1_reg;
                end
                default:
                begin
                    b_msg_next[0] = ST_PITCH + {1'b0, a_cmd_reg};
                    b_msg_next[1] = {1'b0, bend[6:0]};
                    b_msg_next[2] = {1'b0, bend[13:7]};
                end
            endcase
        end
        b_last_next = {2'b00, b_ng_next} + nm;
    end

    assign msg_idx = b_idx_reg - {2'b00, b_ng_reg} - 4'd1;
    assign b_byte  = (b_idx_reg <= {2'b00, b_ng_reg}) ? b_vlq_reg[b_idx_reg[1:0]]
                                                      : b_msg_reg[msg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_now_reg   <= '0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            b_idx_reg      <= '0;
            c_valid_reg    <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (s_xfer && (in_op == OP_TICK))
            begin
                tick_now_reg <= tick_now_reg + 1'b1;
            end
            if (s_xfer)
            begin
                a_valid_reg <= is_event || is_eot;
            end
            else if (a_adv)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_adv)
            begin
                b_valid_reg <= 1'b1;
                b_idx_reg   <= '0;
            end
            else if (b_done)
            begin
                b_valid_reg <= 1'b0;
            end
            else if (b_emit)
            begin
                b_idx_reg <= b_idx_reg + 1'b1;
            end
            if (b_emit)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                c_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            a_eot_reg  <= is_eot;
            a_kind_reg <= in_kind;
            a_d1_reg   <= in_d1;
            a_d2_reg   <= in_d2;
            a_cmd_reg  <= in_cmd;
            a_trk_reg  <= in_trk;
            a_tick_reg <= tick_now_reg;
        end
        if (a_adv)
        begin
            b_vlq_reg  <= b_vlq_next;
            b_msg_reg  <= b_msg_next;
            b_ng_reg   <= b_ng_next;
            b_last_reg <= b_last_next;
            b_trk_reg  <= a_trk_reg;
        end
        if (b_emit)
        begin
            c_byte_reg <= b_byte;
            c_trk_reg  <= b_trk_reg;
            c_last_reg <= (b_idx_reg == b_last_reg);
        end
    end

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = {1'b0, c_trk_reg, c_byte_reg};
    assign m_tlast  = c_last_reg;

endmodule
